/* design/v2n_pkg.sv */
// package: widths and helpers for the 2d vector normaliser
`default_nettype none
package v2n_pkg;
  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 15;
endpackage
`default_nettype wire

/* design/v2n_if.sv */
// interfaces: input and result channels of the normaliser
`default_nettype none
interface v2n_in_if #(parameter int IN_WIDTH = v2n_pkg::IN_WIDTH_DEF) ();
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] vec_x;
  logic signed [IN_WIDTH-1:0] vec_y;
  modport source (output valid, vec_x, vec_y, input ready);
  modport sink (input valid, vec_x, vec_y, output ready);
endinterface

interface v2n_out_if #(parameter int FRAC_BITS = v2n_pkg::FRAC_BITS_DEF) ();
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS:0]   unit_x;
  logic signed [FRAC_BITS:0]   unit_y;
  logic                        zero_length;
  modport source (output valid, unit_x, unit_y, zero_length, input ready);
  modport sink (input valid, unit_x, unit_y, zero_length, output ready);
endinterface
`default_nettype wire

/* design/vector2d_normalize.sv */
// top level: pipelined 2d vector normaliser
// Accepts one vector per cycle while the result side is not stalled, and returns one
// result per vector in order. The pipeline has a magnitude stage, a squares stage,
// one restoring square-root stage per root bit, one shared restoring divide stage
// per quotient bit for both components, and an output register.
// A stall on the result side freezes the whole pipeline with nothing lost.
`default_nettype none
module vector2d_normalize #(
  parameter int IN_WIDTH  = v2n_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = v2n_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  v2n_in_if.sink   in_ch,
  v2n_out_if.source out_ch
);
  localparam int MW = IN_WIDTH + 1;             // magnitude width
  localparam int SW = 2 * MW + 1;               // sum of squares
  localparam int NW = SW + 2 * FRAC_BITS;       // radicand width
  localparam int RB = (NW + 1) / 2;             // root bits
  localparam int QB = FRAC_BITS + 2;            // quotient bits kept (bit QB-1 = saturate)
  localparam int DW = MW + 2 * FRAC_BITS;       // dividend width
  localparam int RW = RB + 2;                   // remainder width
  localparam logic [QB-1:0] LIM = QB'((1 << FRAC_BITS) - 1);

  logic advance;
  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // stage 0: magnitudes
  logic          v0, nx0, ny0;
  logic [MW-1:0] mx0, my0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (advance) v0 <= in_ch.valid;
    if (advance) begin
      nx0 <= in_ch.vec_x[IN_WIDTH-1];
      ny0 <= in_ch.vec_y[IN_WIDTH-1];
      mx0 <= in_ch.vec_x[IN_WIDTH-1] ? MW'(-{in_ch.vec_x[IN_WIDTH-1], in_ch.vec_x})
                                     : MW'(in_ch.vec_x);
      my0 <= in_ch.vec_y[IN_WIDTH-1] ? MW'(-{in_ch.vec_y[IN_WIDTH-1], in_ch.vec_y})
                                     : MW'(in_ch.vec_y);
    end
  end

  // stage 1: squares
  logic          v1, nx1, ny1;
  logic [MW-1:0] mx1, my1;
  logic [SW-1:0] s1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= v0;
    if (advance) begin
      nx1 <= nx0; ny1 <= ny0; mx1 <= mx0; my1 <= my0;
      s1  <= SW'(mx0 * mx0) + SW'(my0 * my0);
    end
  end

  // square root stages: digit-by-digit, two radicand bits per stage
  logic          rv  [RB+1];
  logic          rnx [RB+1];
  logic          rny [RB+1];
  logic          rz  [RB+1];
  logic [MW-1:0] rmx [RB+1];
  logic [MW-1:0] rmy [RB+1];
  logic [2*RB-1:0] rad [RB+1];
  logic [RW-1:0] rrem [RB+1];
  logic [RB-1:0] root [RB+1];

  always_comb begin
    rv[0] = v1; rnx[0] = nx1; rny[0] = ny1; rmx[0] = mx1; rmy[0] = my1;
    rz[0] = (s1 == '0);
    rad[0] = (2*RB)'({s1, {(2*FRAC_BITS){1'b0}}});
    rrem[0] = '0; root[0] = '0;
  end

  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    logic [RW-1:0] trial, cand;
    always_comb begin
      trial = RW'({rrem[g], rad[g][2*RB-1 -: 2]});
      cand  = RW'({root[g], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) rv[g+1] <= 1'b0;
      else if (advance) rv[g+1] <= rv[g];
      if (advance) begin
        rnx[g+1] <= rnx[g]; rny[g+1] <= rny[g]; rz[g+1] <= rz[g];
        rmx[g+1] <= rmx[g]; rmy[g+1] <= rmy[g];
        rad[g+1] <= rad[g] << 2;
        if (trial >= cand) begin
          rrem[g+1] <= trial - cand;
          root[g+1] <= {root[g][RB-2:0], 1'b1};
        end else begin
          rrem[g+1] <= trial;
          root[g+1] <= {root[g][RB-2:0], 1'b0};
        end
      end
    end
  end

  // divide stages: both components share each stage, one quotient bit a stage
  // high dividend bits above QB quotient bits feed the saturate flag and seed the first remainder
  logic          dv  [QB+1];
  logic          dnx [QB+1];
  logic          dny [QB+1];
  logic          dz  [QB+1];
  logic [RB-1:0] den [QB+1];
  logic [DW-1:0] nux [QB+1];
  logic [DW-1:0] nuy [QB+1];
  logic [RB:0]   rex [QB+1];
  logic [RB:0]   rey [QB+1];
  logic [QB-1:0] qx  [QB+1];
  logic [QB-1:0] qy  [QB+1];
  logic          sx  [QB+1];
  logic          sy  [QB+1];

  // the top DW-QB dividend bits give a leading quotient part; any nonzero part saturates
  logic [DW-1:0] dvx, dvy;
  always_comb begin
    dvx = {rmx[RB], {(2*FRAC_BITS){1'b0}}};
    dvy = {rmy[RB], {(2*FRAC_BITS){1'b0}}};
    dv[0] = rv[RB]; dnx[0] = rnx[RB]; dny[0] = rny[RB]; dz[0] = rz[RB];
    den[0] = root[RB];
    nux[0] = dvx; nuy[0] = dvy;
    rex[0] = '0; rey[0] = '0; qx[0] = '0; qy[0] = '0; sx[0] = 1'b0; sy[0] = 1'b0;
  end

  // each stage brings in one dividend bit; the first DW-QB bits accumulate into
  // the remainder too, but a stage can only handle one, so leading bits are
  // checked as a whole: quotient >= 2^QB when (dividend >> QB) >= den
  logic [DW-1:0] hix, hiy;
  logic          hsx, hsy;
  always_comb begin
    hix = dvx >> QB;
    hiy = dvy >> QB;
    hsx = (hix >= DW'(root[RB]));
    hsy = (hiy >= DW'(root[RB]));
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [RB+1:0] tx, ty;
    logic [RB-1:0] rsx, rsy;
    always_comb begin
      if (g == 0) begin
        rsx = RB'(hix); rsy = RB'(hiy);
      end else begin
        rsx = rex[g][RB-1:0]; rsy = rey[g][RB-1:0];
      end
      tx = {1'b0, rsx, nux[g][QB-1-g]};
      ty = {1'b0, rsy, nuy[g][QB-1-g]};
    end
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else if (advance) dv[g+1] <= dv[g];
      if (advance) begin
        dnx[g+1] <= dnx[g]; dny[g+1] <= dny[g]; dz[g+1] <= dz[g]; den[g+1] <= den[g];
        nux[g+1] <= nux[g]; nuy[g+1] <= nuy[g];
        sx[g+1] <= (g == 0) ? (hsx && !dz[g]) : sx[g];
        sy[g+1] <= (g == 0) ? (hsy && !dz[g]) : sy[g];
        if (tx >= (RB+2)'(den[g])) begin
          rex[g+1] <= (RB+1)'(tx - (RB+2)'(den[g]));
          qx[g+1]  <= {qx[g][QB-2:0], 1'b1};
        end else begin
          rex[g+1] <= (RB+1)'(tx);
          qx[g+1]  <= {qx[g][QB-2:0], 1'b0};
        end
        if (ty >= (RB+2)'(den[g])) begin
          rey[g+1] <= (RB+1)'(ty - (RB+2)'(den[g]));
          qy[g+1]  <= {qy[g][QB-2:0], 1'b1};
        end else begin
          rey[g+1] <= (RB+1)'(ty);
          qy[g+1]  <= {qy[g][QB-2:0], 1'b0};
        end
      end
    end
  end

  // output register: saturate, sign, zero
  logic [QB-1:0] fx, fy;
  always_comb begin
    fx = (sx[QB] || qx[QB] > LIM) ? LIM : qx[QB];
    fy = (sy[QB] || qy[QB] > LIM) ? LIM : qy[QB];
  end
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (advance) out_ch.valid <= dv[QB];
    if (advance) begin
      out_ch.zero_length <= dz[QB];
      out_ch.unit_x <= dz[QB] ? '0 : (dnx[QB] ? -(FRAC_BITS+1)'(fx) : (FRAC_BITS+1)'(fx));
      out_ch.unit_y <= dz[QB] ? '0 : (dny[QB] ? -(FRAC_BITS+1)'(fy) : (FRAC_BITS+1)'(fy));
    end
  end

  initial_unused_check: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.unit_x))
    else $error("stalled result changed");
  zero_ok: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.zero_length |-> out_ch.unit_x == '0 && out_ch.unit_y == '0)
    else $error("zero vector gave nonzero result");
  sat_ok: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.unit_x != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("result outside saturation range");
  ready_ok: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
endmodule
`default_nettype wire
